[hw/rtl/header_framed_command_parser_core_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the header-framed command parser
// Immediate-implication and next-cycle checks, clocked and reset-gated.
// ---------------------------------------------------------------------------
`ifndef HEADER_FRAMED_COMMAND_PARSER_CORE_DEFINES_SVH
`define HEADER_FRAMED_COMMAND_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define HFCP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HFCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/hfcp_pkg.sv]
// ---------------------------------------------------------------------------
// hfcp_pkg
// Shared types and constants of the header-framed command parser.
// ---------------------------------------------------------------------------
package hfcp_pkg;

  localparam int LED_NUMBER_DEF      = 16;
  localparam int RECEIVER_NUMBER_DEF = 16;

  localparam logic [7:0] HDR_FIRST    = 8'h84;
  localparam logic [7:0] HDR_SECOND   = 8'h6F;
  localparam logic [5:0] PACKET_BYTES = 6'd59;
  localparam logic [5:0] OFS_BRIGHT   = 6'd7;
  localparam logic [5:0] OFS_MASK     = 6'd23;
  localparam logic [5:0] OFS_POWER    = 6'd55;
  localparam logic [7:0] RATE_RESET   = 8'd50;

  // payload cells hold offsets 7..58
  localparam int STORE_DEPTH = 52;
  // control bytes power, storage, rate, start
  localparam int CTRL_BYTES  = 4;
  // drain position at which the control bytes sit at the head of the chain
  localparam logic [5:0] CTRL_POS = OFS_POWER - OFS_BRIGHT;

  typedef enum logic [1:0] {
    HUNT_FIRST  = 2'd0,
    HUNT_SECOND = 2'd1,
    COLLECT     = 2'd2
  } hunt_t;

  typedef enum logic [1:0] {
    KIND_BRIGHT = 2'd0,
    KIND_MASK   = 2'd1,
    KIND_CTRL   = 2'd2
  } kind_t;

  typedef logic [7:0] byte_t;

endpackage

[hw/rtl/hfcp_cell.sv]
// ---------------------------------------------------------------------------
// hfcp_cell
// One byte of the payload chain; loads its neighbor's byte on a shift.
// ---------------------------------------------------------------------------
module hfcp_cell (
  input  logic           clk,
  input  logic           shift,
  input  hfcp_pkg::byte_t din,
  output hfcp_pkg::byte_t dout
);

  hfcp_pkg::byte_t data;

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= din;
    end
  end

  assign dout = data;

endmodule

[hw/rtl/hfcp_chain.sv]
// ---------------------------------------------------------------------------
// hfcp_chain
// Row of payload cells. Bytes enter at the tail and move toward the head.
// ---------------------------------------------------------------------------
module hfcp_chain (
  input  logic            clk,
  input  logic            shift,
  input  hfcp_pkg::byte_t tail_in,
  output hfcp_pkg::byte_t head [hfcp_pkg::CTRL_BYTES]
);

  hfcp_pkg::byte_t link [hfcp_pkg::STORE_DEPTH + 1];

  assign link[hfcp_pkg::STORE_DEPTH] = tail_in;

  for (genvar i = 0; i < hfcp_pkg::STORE_DEPTH; i++) begin : g_cell
    hfcp_cell u_cell (
      .clk  (clk),
      .shift(shift),
      .din  (link[i+1]),
      .dout (link[i])
    );
  end

  for (genvar j = 0; j < hfcp_pkg::CTRL_BYTES; j++) begin : g_head
    assign head[j] = link[j];
  end

endmodule

[hw/rtl/header_framed_command_parser_core.sv]
// ---------------------------------------------------------------------------
// header_framed_command_parser_core
// Hunts for the 0x84 0x6F header, collects a 59-byte packet into a cell
// chain and drains brightness, channel-mask and control requests from it.
// ---------------------------------------------------------------------------
// Rate: one input byte per cycle while collecting; header and filler bytes
//   give no request.
// The completing byte starts a drain (one chain shift a cycle, 48 shifts
//   plus the control request), stretched by output stalls; no byte is taken
//   during the drain.
// The edge that takes the last byte sets busy; the first brightness request
//   is then loaded into the output register when the drain advances.
// Reset (rst, synchronous, active high): hunting, byte count 0, power 1,
//   storage 0, rate 50, start 0, output empty. Chain contents are not reset.
// ---------------------------------------------------------------------------
`include "header_framed_command_parser_core_defines.svh"

module header_framed_command_parser_core #(
  parameter int LED_NUMBER      = hfcp_pkg::LED_NUMBER_DEF,
  parameter int RECEIVER_NUMBER = hfcp_pkg::RECEIVER_NUMBER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // slave side: received bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  // master side: parsed requests
  output logic        m_tvalid,
  input  logic        m_tready,
  // index[4:0], value[12:5], power_on[13], storage_on[14], sample_rate[22:15],
  // start_on[23], power_changed[24], storage_changed[25], rate_changed[26],
  // start_changed[27], zero[31:28]
  output logic [31:0] m_tdata,
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast    // last
);

  localparam int MASK_BYTES = (LED_NUMBER * RECEIVER_NUMBER) / 8;
  // drain positions (offset minus 7) of each request group
  localparam logic [5:0] LED_END  = 6'(LED_NUMBER);
  localparam logic [5:0] MASK_BEG = hfcp_pkg::OFS_MASK - hfcp_pkg::OFS_BRIGHT;
  localparam logic [5:0] MASK_END = 6'(32'(MASK_BEG) + MASK_BYTES);

  // ---- header hunt and byte count ----
  hfcp_pkg::hunt_t hunt, hunt_next;
  logic [5:0]      byte_count, byte_count_next;
  logic            in_acc;
  logic            store_byte;   // byte lands in the chain
  logic            complete;     // packet's final byte accepted

  // ---- drain sequencer ----
  logic       busy;              // draining the chain
  logic [5:0] pos;               // offset - 7 of the byte at chain head
  logic       advance;
  logic       emit_bright, emit_mask, emit_ctrl;

  // ---- stored settings ----
  logic       power_state, storage_state, start_state;
  logic [7:0] rate_state;

  hfcp_pkg::byte_t head [hfcp_pkg::CTRL_BYTES];
  logic       pc, sc, rc, tc;
  logic       power_new, storage_new, start_new;
  logic [7:0] rate_new;

  assign s_tready = !busy;
  assign in_acc   = s_tvalid && s_tready;

  // next state of the header hunt; the code left over behaves like hunting
  always_comb begin
    hunt_next       = hunt;
    byte_count_next = byte_count;
    store_byte      = 1'b0;
    complete        = 1'b0;
    if (in_acc) begin
      unique case (hunt)
        hfcp_pkg::HUNT_SECOND: begin
          if (s_tdata == hfcp_pkg::HDR_SECOND) begin
            hunt_next       = hfcp_pkg::COLLECT;
            byte_count_next = 6'd2;
          end else begin
            hunt_next       = hfcp_pkg::HUNT_FIRST;
            byte_count_next = 6'd0;
          end
        end
        hfcp_pkg::COLLECT: begin
          store_byte = (byte_count >= hfcp_pkg::OFS_BRIGHT);
          if (byte_count + 6'd1 == hfcp_pkg::PACKET_BYTES) begin
            complete        = 1'b1;
            hunt_next       = hfcp_pkg::HUNT_FIRST;
            byte_count_next = 6'd0;
          end else begin
            byte_count_next = byte_count + 6'd1;
          end
        end
        default: begin
          if (s_tdata == hfcp_pkg::HDR_FIRST) begin
            hunt_next       = hfcp_pkg::HUNT_SECOND;
            byte_count_next = 6'd1;
          end else begin
            hunt_next       = hfcp_pkg::HUNT_FIRST;
            byte_count_next = 6'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt       <= hfcp_pkg::HUNT_FIRST;
      byte_count <= 6'd0;
    end else begin
      hunt       <= hunt_next;
      byte_count <= byte_count_next;
    end
  end

  // payload chain: collection shifts bytes in, the drain shifts them out
  assign advance     = busy && (!m_tvalid || m_tready);
  assign emit_bright = (pos < LED_END);
  assign emit_mask   = (pos >= MASK_BEG) && (pos < MASK_END);
  assign emit_ctrl   = (pos == hfcp_pkg::CTRL_POS);

  hfcp_chain u_chain (
    .clk    (clk),
    .shift  (store_byte || (advance && !emit_ctrl)),
    .tail_in(s_tdata),
    .head   (head)
  );

  // control bytes are at the head once 48 shifts have gone by
  assign pc = (head[0] != {7'd0, power_state});
  assign sc = (head[1] != {7'd0, storage_state});
  assign rc = (head[2] != rate_state);
  assign tc = (head[3] != {7'd0, start_state});
  assign power_new   = pc ? (head[0] != 8'd0) : power_state;
  assign storage_new = sc ? (head[1] != 8'd0) : storage_state;
  assign rate_new    = rc ? head[2] : rate_state;
  assign start_new   = tc ? (head[3] != 8'd0) : start_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      pos           <= 6'd0;
      power_state   <= 1'b1;
      storage_state <= 1'b0;
      rate_state    <= hfcp_pkg::RATE_RESET;
      start_state   <= 1'b0;
    end else begin
      if (complete) begin
        busy <= 1'b1;
        pos  <= 6'd0;
      end else if (advance) begin
        if (emit_ctrl) begin
          busy          <= 1'b0;
          power_state   <= power_new;
          storage_state <= storage_new;
          rate_state    <= rate_new;
          start_state   <= start_new;
        end else begin
          pos <= pos + 6'd1;
        end
      end
    end
  end

  // output register: new input bytes can be taken while the control request waits here
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && (emit_bright || emit_mask || emit_ctrl)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      priority if (emit_ctrl) begin
        m_tuser <= hfcp_pkg::KIND_CTRL;
        m_tlast <= 1'b1;
        m_tdata <= {4'd0, tc, rc, sc, pc, start_new, rate_new, storage_new,
                    power_new, 8'd0, 5'd0};
      end else if (emit_bright) begin
        m_tuser <= hfcp_pkg::KIND_BRIGHT;
        m_tlast <= 1'b0;
        m_tdata <= {19'd0, head[0], pos[4:0]};
      end else if (emit_mask) begin
        m_tuser <= hfcp_pkg::KIND_MASK;
        m_tlast <= 1'b0;
        m_tdata <= {19'd0, head[0], 5'(pos - MASK_BEG)};
      end else begin
        m_tlast <= m_tlast;
      end
    end
  end

  // ---- checks ----
  `HFCP_ASSERT_NEXT(a_complete_starts_drain, clk, rst, complete,
                    busy && pos == 6'd0, "packet completion did not start the drain")
  `HFCP_ASSERT_NOW(a_drain_while_hunting, clk, rst, busy,
                   hunt == hfcp_pkg::HUNT_FIRST && byte_count == 6'd0,
                   "drain running outside the hunting state")
  `HFCP_ASSERT_NOW(a_last_is_ctrl, clk, rst, m_tvalid && m_tlast,
                   m_tuser == hfcp_pkg::KIND_CTRL, "last request is not a control request")
  `HFCP_ASSERT_NEXT(a_pos_steps, clk, rst, advance && !emit_ctrl,
                    pos == $past(pos) + 6'd1, "drain position did not step by one")

endmodule

[test/tb.sv]
// ---------------------------------------------------------------------------
// tb: testbench of header_framed_command_parser_core
// Streams received bytes into the parser and checks every drained request,
// field by field, against a packet decoder kept inside the bench. A table of
// directed packets runs first, then random packets with noise between them,
// under three patterns of source gaps and sink stalls.
// ---------------------------------------------------------------------------
module tb;

  localparam int N_BRIGHT    = hfcp_pkg::LED_NUMBER_DEF;
  localparam int MASK_BYTES  = (hfcp_pkg::LED_NUMBER_DEF * hfcp_pkg::RECEIVER_NUMBER_DEF) / 8;
  localparam int FULL_BODY   = 57;        // bytes after the header
  localparam int TAIL_CYCLES = 60;        // time for the drain and the output register
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {
    FILL_CONST = 2'd0,
    FILL_RAMP  = 2'd1,
    FILL_RAND  = 2'd2
  } fill_t;

  typedef struct packed {
    logic            power_on;
    logic            storage_on;
    hfcp_pkg::byte_t sample_rate;
    logic            start_on;
    logic            power_changed;
    logic            storage_changed;
    logic            rate_changed;
    logic            start_changed;
  } ctrl_t;

  typedef struct packed {
    hfcp_pkg::kind_t kind;
    logic [4:0]      index;
    hfcp_pkg::byte_t value;
    ctrl_t           ctrl;
    logic            last;
  } req_t;

  // one packet of stimulus: noise, header, body (cut short when len < 57)
  typedef struct packed {
    logic [2:0][7:0] junk;
    logic [1:0]      nj;
    fill_t           mode;
    hfcp_pkg::byte_t fill;
    logic [3:0][7:0] ctl;
    logic [5:0]      len;
  } frame_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  header_framed_command_parser_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // decoder state, at its reset values
  hfcp_pkg::hunt_t hunt       = hfcp_pkg::HUNT_FIRST;
  logic [5:0]      pos        = '0;
  hfcp_pkg::byte_t payload [hfcp_pkg::STORE_DEPTH];
  logic            st_power   = 1'b1;
  logic            st_storage = 1'b0;
  hfcp_pkg::byte_t st_rate    = hfcp_pkg::RATE_RESET;
  logic            st_start   = 1'b0;
  int              pkt_no     = 0;

  // control request typed in by hand for the directed packets
  ctrl_t      pinned_ctrl [16];
  bit         pinned_on   [16];

  req_t       pending_reqs [$];
  frame_t     frame_table  [$];
  logic [3:0][7:0] prev_ctl = '0;

  int src_gap_pct   = 0;
  int snk_stall_pct = 0;
  int bytes_sent    = 0;
  int n_errors      = 0;
  int cycles        = 0;

  // Decodes one accepted byte and queues the requests it releases.
  task automatic parse_byte(input hfcp_pkg::byte_t b);
    req_t            r;
    hfcp_pkg::byte_t pb, sb, rb, tb;
    case (hunt)
      hfcp_pkg::HUNT_SECOND: begin
        // a bad second byte is dropped, never retried as a first byte
        if (b == hfcp_pkg::HDR_SECOND) begin
          pos  = 6'd2;
          hunt = hfcp_pkg::COLLECT;
        end else begin
          pos  = '0;
          hunt = hfcp_pkg::HUNT_FIRST;
        end
      end
      hfcp_pkg::COLLECT: begin
        // offsets 2..6 are counted only
        if (pos >= hfcp_pkg::OFS_BRIGHT) payload[pos - hfcp_pkg::OFS_BRIGHT] = b;
        pos = pos + 6'd1;
        if (pos == hfcp_pkg::PACKET_BYTES) begin
          pos  = '0;
          hunt = hfcp_pkg::HUNT_FIRST;
          for (int i = 0; i < N_BRIGHT; i++) begin
            r       = '0;
            r.kind  = hfcp_pkg::KIND_BRIGHT;
            r.index = 5'(i);
            r.value = payload[i];
            pending_reqs.push_back(r);
          end
          for (int i = 0; i < MASK_BYTES; i++) begin
            r       = '0;
            r.kind  = hfcp_pkg::KIND_MASK;
            r.index = 5'(i);
            r.value = payload[hfcp_pkg::OFS_MASK - hfcp_pkg::OFS_BRIGHT + i];
            pending_reqs.push_back(r);
          end
          pb = payload[hfcp_pkg::OFS_POWER - hfcp_pkg::OFS_BRIGHT];
          sb = payload[hfcp_pkg::OFS_POWER - hfcp_pkg::OFS_BRIGHT + 1];
          rb = payload[hfcp_pkg::OFS_POWER - hfcp_pkg::OFS_BRIGHT + 2];
          tb = payload[hfcp_pkg::OFS_POWER - hfcp_pkg::OFS_BRIGHT + 3];
          r      = '0;
          r.kind = hfcp_pkg::KIND_CTRL;
          r.last = 1'b1;
          // whole byte against the stored bit: 0x55 vs 1 counts as changed
          r.ctrl.power_changed   = (pb != {7'd0, st_power});
          r.ctrl.storage_changed = (sb != {7'd0, st_storage});
          r.ctrl.rate_changed    = (rb != st_rate);
          r.ctrl.start_changed   = (tb != {7'd0, st_start});
          if (r.ctrl.power_changed)   st_power   = (pb != 8'd0);
          if (r.ctrl.storage_changed) st_storage = (sb != 8'd0);
          if (r.ctrl.rate_changed)    st_rate    = rb;
          if (r.ctrl.start_changed)   st_start   = (tb != 8'd0);
          r.ctrl.power_on    = st_power;
          r.ctrl.storage_on  = st_storage;
          r.ctrl.sample_rate = st_rate;
          r.ctrl.start_on    = st_start;
          if (pkt_no < 16 && pinned_on[pkt_no]) begin
            r.ctrl     = pinned_ctrl[pkt_no];
            st_power   = r.ctrl.power_on;
            st_storage = r.ctrl.storage_on;
            st_rate    = r.ctrl.sample_rate;
            st_start   = r.ctrl.start_on;
          end
          pending_reqs.push_back(r);
          pkt_no++;
        end
      end
      default: begin
        if (b == hfcp_pkg::HDR_FIRST) begin
          pos  = 6'd1;
          hunt = hfcp_pkg::HUNT_SECOND;
        end else begin
          pos  = '0;
          hunt = hfcp_pkg::HUNT_FIRST;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  task automatic check_request();
    req_t w;
    if (pending_reqs.size() == 0) begin
      $error("request with none pending: kind %0h, tdata %0h, last %0b",
             m_tuser, m_tdata, m_tlast);
      n_errors++;
    end else begin
      w = pending_reqs.pop_front();
      check_field("kind", 32'(w.kind), 32'(m_tuser));
      check_field("index", 32'(w.index), 32'(m_tdata[4:0]));
      check_field("value", 32'(w.value), 32'(m_tdata[12:5]));
      check_field("power_on", 32'(w.ctrl.power_on), 32'(m_tdata[13]));
      check_field("storage_on", 32'(w.ctrl.storage_on), 32'(m_tdata[14]));
      check_field("sample_rate", 32'(w.ctrl.sample_rate), 32'(m_tdata[22:15]));
      check_field("start_on", 32'(w.ctrl.start_on), 32'(m_tdata[23]));
      check_field("power_changed", 32'(w.ctrl.power_changed), 32'(m_tdata[24]));
      check_field("storage_changed", 32'(w.ctrl.storage_changed), 32'(m_tdata[25]));
      check_field("rate_changed", 32'(w.ctrl.rate_changed), 32'(m_tdata[26]));
      check_field("start_changed", 32'(w.ctrl.start_changed), 32'(m_tdata[27]));
      check_field("pad", 32'd0, 32'(m_tdata[31:28]));
      check_field("last", 32'(w.last), 32'(m_tlast));
    end
  endtask

  // Both handshakes are sampled on the edge, before any bench drive lands.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) parse_byte(s_tdata);
      if (m_tvalid && m_tready) check_request();
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("header_framed_command_parser_core: mismatch");
      $finish;
    end
  end

  // Holds one byte until it is taken; valid stays up between back-to-back bytes.
  task automatic send_byte(input hfcp_pkg::byte_t b);
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_t f);
    for (int k = 0; k < f.nj; k++) send_byte(f.junk[k]);
    send_byte(hfcp_pkg::HDR_FIRST);
    send_byte(hfcp_pkg::HDR_SECOND);
    for (int o = 2; o < 2 + f.len; o++) begin
      if (o >= hfcp_pkg::OFS_POWER) begin
        send_byte(f.ctl[o - hfcp_pkg::OFS_POWER]);
      end else begin
        case (f.mode)
          FILL_CONST: send_byte(f.fill);
          FILL_RAMP:  send_byte(8'(32'(f.fill) + o));
          default:    send_byte(8'($urandom));
        endcase
      end
    end
  endtask

  function automatic ctrl_t ctrl_word(input bit p, input bit s,
                                      input hfcp_pkg::byte_t r,
                                      input bit t, input bit pc, input bit sc,
                                      input bit rc, input bit tc);
    ctrl_t c;
    c.power_on        = p;
    c.storage_on      = s;
    c.sample_rate     = r;
    c.start_on        = t;
    c.power_changed   = pc;
    c.storage_changed = sc;
    c.rate_changed    = rc;
    c.start_changed   = tc;
    return c;
  endfunction

  task automatic add_row(input hfcp_pkg::byte_t j0, input hfcp_pkg::byte_t j1,
                         input hfcp_pkg::byte_t j2, input int nj,
                         input fill_t mode, input hfcp_pkg::byte_t fill,
                         input hfcp_pkg::byte_t p, input hfcp_pkg::byte_t s,
                         input hfcp_pkg::byte_t r, input hfcp_pkg::byte_t t,
                         input bit pin, input ctrl_t want);
    frame_t f;
    f.junk = {j2, j1, j0};
    f.nj   = 2'(nj);
    f.mode = mode;
    f.fill = fill;
    f.ctl  = {t, r, s, p};
    f.len  = 6'(FULL_BODY);
    pinned_on[frame_table.size()]   = pin;
    pinned_ctrl[frame_table.size()] = want;
    frame_table.push_back(f);
  endtask

  // Mostly whole packets with random content; some noise ahead of the header,
  // now and then a header-like byte there, and a few packets cut short.
  function automatic frame_t rand_frame();
    frame_t f;
    f.nj = 2'($urandom_range(0, 3));
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 7))
        0:       f.junk[k] = hfcp_pkg::HDR_FIRST;
        1:       f.junk[k] = hfcp_pkg::HDR_SECOND;
        default: f.junk[k] = 8'($urandom);
      endcase
    end
    case ($urandom_range(0, 5))
      0:       f.mode = FILL_CONST;
      1:       f.mode = FILL_RAMP;
      default: f.mode = FILL_RAND;
    endcase
    f.fill = 8'($urandom);
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 3))
        0:       f.ctl[k] = 8'h00;
        1:       f.ctl[k] = 8'h01;
        2:       f.ctl[k] = prev_ctl[k];
        default: f.ctl[k] = 8'($urandom);
      endcase
    end
    prev_ctl = f.ctl;
    f.len = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, FULL_BODY - 1))
                                        : 6'(FULL_BODY);
    return f;
  endfunction

  initial begin
    int start;
    // directed packets; control state after reset is power 1, storage 0,
    // rate 50, start 0
    // all zeros: power and rate change
    add_row(8'h00, 8'h00, 8'h00, 0, FILL_CONST, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            1'b1, ctrl_word(1'b0, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
    // all ones: every setting changes
    add_row(8'h00, 8'h00, 8'h00, 0, FILL_CONST, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            1'b1, ctrl_word(1'b1, 1'b1, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    // 84 84 6F: bad second byte, the second 84 is dropped, not a new header;
    // 0x55 vs stored 1 counts as changed
    add_row(hfcp_pkg::HDR_FIRST, hfcp_pkg::HDR_FIRST, hfcp_pkg::HDR_SECOND, 3,
            FILL_RAND, 8'h00, 8'h55, 8'h01, 8'hFF, 8'h01,
            1'b1, ctrl_word(1'b1, 1'b1, 8'd255, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    // noise in hunt, body full of header bytes; power 0, storage 0, rate 50, start 0
    add_row(hfcp_pkg::HDR_SECOND, 8'hFF, 8'h00, 3, FILL_CONST, hfcp_pkg::HDR_FIRST,
            8'h00, 8'h00, hfcp_pkg::RATE_RESET, 8'h00,
            1'b1, ctrl_word(1'b0, 1'b0, hfcp_pkg::RATE_RESET, 1'b0,
                            1'b1, 1'b1, 1'b1, 1'b1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    src_gap_pct   = 12;
    snk_stall_pct = 70;
    foreach (frame_table[i]) send_frame(frame_table[i]);

    // random packets: sink stalls, then source gaps, then full rate
    for (int ph = 0; ph < 3; ph++) begin
      src_gap_pct   = (ph == 0) ? 12 : (ph == 1) ? 70 : 0;
      snk_stall_pct = (ph == 0) ? 70 : (ph == 1) ? 12 : 0;
      start = bytes_sent;
      while (bytes_sent - start < 55) send_frame(rand_frame());
    end
    s_tvalid <= 1'b0;

    while (pending_reqs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("header_framed_command_parser_core: match");
    end else begin
      $display("header_framed_command_parser_core: mismatch");
    end
    $finish;
  end

endmodule

[header_framed_command_parser_core.f]
+incdir+hw/rtl
hw/rtl/hfcp_pkg.sv
hw/rtl/hfcp_cell.sv
hw/rtl/hfcp_chain.sv
hw/rtl/header_framed_command_parser_core.sv
test/tb.sv
